FILE: src/lcdr_pkg.sv
`timescale 1ns / 1ps

package lcdr_pkg;

	// Item codes carried on the mode field.
	localparam logic [1:0] MODE_WRITE      = 2'd0;
	localparam logic [1:0] MODE_START_FAST = 2'd1;
	localparam logic [1:0] MODE_START_FULL = 2'd2;
	localparam logic [1:0] MODE_PULL       = 2'd3;

	// Register indexes on the configuration port (byte address is four times this).
	localparam logic [1:0] REG_PAD_COLUMNS = 2'd0;
	localparam logic [1:0] REG_OLED_PANEL  = 2'd1;
	localparam logic [1:0] REG_FULL_PASSES = 2'd2;

	localparam logic [2:0] FULL_PASSES_RESET = 3'd2;

	// Panel command bytes.
	localparam logic [7:0] CMD_COL_LOW    = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
	localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'hAF;
	localparam logic [7:0] CMD_OLED_ON    = 8'hA4;

	// Number of zero bytes on each side of a page when padding is on.
	localparam int PAD_BYTES = 2;

	typedef struct packed {
		logic clear_step;
		logic write;
		logic start_fast;
		logic start_full;
		logic pull;
		logic load_out;
	} lcdr_cmd_t;

	typedef struct packed {
		logic phase_idle;
		logic clear_last;
	} lcdr_sts_t;

endpackage

FILE: src/page_lcd_refresh_sequencer.sv
`timescale 1ns / 1ps

// Page-mode LCD refresh sequencer. The block keeps a page-organized frame
// buffer (one byte holds eight vertical pixels) and turns it into the byte
// stream for a serial panel link. Each item on the request channel either
// writes one buffer byte, starts a fast refresh (one half of the buffer,
// alternating halves), starts a full refresh (full_passes half passes, at
// least one, then a display-on command), or pulls the next byte of the
// running refresh. Only a pull during a refresh returns a beat on the
// response channel; it carries the byte, the data/command select level,
// whether chip select is released after it, and whether it is the last
// byte of the refresh. A start item that arrives while a refresh is running
// is dropped. A pull that yields a byte goes through the frame buffer
// memory's registered read port: the byte is fetched in the cycle the pull
// is taken, and the block then waits in its load state until the output
// register is free and moves the byte into it. No new item is taken while
// the block is in the load state. The output register lets the next item in
// while a finished beat is still stalled. After reset the block zeroes the
// frame buffer one byte per cycle, and req_stall stays high until every
// byte is cleared. Configuration writes are taken at any time, clearing pass
// included, but should only be issued while no refresh is running.

module page_lcd_refresh_sequencer #(
	parameter int COLUMNS        = 128,
	parameter int PAGES_PER_PASS = 4,
	parameter int BUFFER_BYTES   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,

	// Request channel.
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  mode,
	input  logic [9:0]  address,
	input  logic [7:0]  data,

	// Response channel.
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  out_byte,
	output logic        is_data,
	output logic        frame_end,
	output logic        refresh_done,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import lcdr_pkg::*;

	// Configuration registers.
	logic       pad_columns_q;
	logic       oled_panel_q;
	logic [2:0] full_passes_q;
	logic       cfg_write;
	logic [1:0] reg_index;

	lcdr_cmd_t  cmd;
	lcdr_sts_t  sts;

	// The port never inserts wait states.
	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// Registers sit on word addresses; a write past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_columns_q <= 1'b0;
			oled_panel_q  <= 1'b0;
			full_passes_q <= FULL_PASSES_RESET;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_PAD_COLUMNS: pad_columns_q <= pwdata[0];
				REG_OLED_PANEL:  oled_panel_q  <= pwdata[0];
				REG_FULL_PASSES: full_passes_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_PAD_COLUMNS: prdata = {31'd0, pad_columns_q};
			REG_OLED_PANEL:  prdata = {31'd0, oled_panel_q};
			REG_FULL_PASSES: prdata = {29'd0, full_passes_q};
			default:         prdata = '0;
		endcase
	end

	// The controller owns the handshakes and the clearing pass; the datapath
	// holds the buffer, the page and byte counters and the output register.
	lcdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode     (mode),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcdr_dp #(
		.COLUMNS       (COLUMNS),
		.PAGES_PER_PASS(PAGES_PER_PASS),
		.BUFFER_BYTES  (BUFFER_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.address     (address),
		.data        (data),
		.pad_columns (pad_columns_q),
		.oled_panel  (oled_panel_q),
		.full_passes (full_passes_q),
		.out_byte    (out_byte),
		.is_data     (is_data),
		.frame_end   (frame_end),
		.refresh_done(refresh_done)
	);

endmodule

FILE: src/lcdr_ram.sv
`timescale 1ns / 1ps

module lcdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/lcdr_ctrl.sv
`timescale 1ns / 1ps

module lcdr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          mode,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  lcdr_pkg::lcdr_sts_t sts,
	output lcdr_pkg::lcdr_cmd_t cmd
);

	import lcdr_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_RUN,
		S_LOAD
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   rsp_valid_q;
	logic   accept;
	logic   out_free;

	assign accept    = req_valid && (state_q == S_RUN);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_RUN);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_nx = S_RUN;
				end
			end
			S_RUN: begin
				if (accept) begin
					unique case (mode)
						MODE_WRITE:      cmd.write      = 1'b1;
						MODE_START_FAST: cmd.start_fast = sts.phase_idle;
						MODE_START_FULL: cmd.start_full = sts.phase_idle;
						MODE_PULL: begin
							if (!sts.phase_idle) begin
								cmd.pull = 1'b1;
								state_nx = S_LOAD;
							end
						end
						default: ;
					endcase
				end
			end
			S_LOAD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_RUN;
				end
			end
			default: state_nx = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(rsp_valid_q && rsp_stall))
		else $error("result register loaded while its beat is still stalled");

	a_pull_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pull |=> (state_q == S_LOAD) && !cmd.pull)
		else $error("pull not followed by the output load cycle");

	a_clear_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !cmd.write && !cmd.pull && !cmd.start_fast
			&& !cmd.start_full)
		else $error("item taken during the buffer clearing pass");

endmodule

FILE: src/lcdr_dp.sv
`timescale 1ns / 1ps

module lcdr_dp #(
	parameter int COLUMNS        = 128,
	parameter int PAGES_PER_PASS = 4,
	parameter int BUFFER_BYTES   = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lcdr_pkg::lcdr_cmd_t cmd,
	output lcdr_pkg::lcdr_sts_t sts,
	input  logic [9:0]          address,
	input  logic [7:0]          data,
	input  logic                pad_columns,
	input  logic                oled_panel,
	input  logic [2:0]          full_passes,
	output logic [7:0]          out_byte,
	output logic                is_data,
	output logic                frame_end,
	output logic                refresh_done
);

	import lcdr_pkg::*;

	localparam int AW     = $clog2(BUFFER_BYTES);
	localparam int POS_W  = $clog2(COLUMNS + 7);
	localparam int DW     = POS_W + 1;
	localparam int PG_W   = (PAGES_PER_PASS > 1) ? $clog2(PAGES_PER_PASS) : 1;
	localparam int ABS_W  = (PAGES_PER_PASS > 1) ? $clog2(2 * PAGES_PER_PASS) : 1;
	localparam int IDX_W  = $clog2(2 * PAGES_PER_PASS * COLUMNS) + 1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FAST,
		PH_FULL,
		PH_FINAL
	} phase_t;

	phase_t            phase_q, phase_nx;
	logic              half_q, half_nx;
	logic [PG_W-1:0]   page_q, page_nx;
	logic [POS_W-1:0]  pos_q, pos_nx;
	logic [2:0]        passes_q, passes_nx;
	logic [AW-1:0]     clr_q;

	logic [7:0]        ob_s1;
	logic              mem_s1, isd_s1, fe_s1, done_s1;
	logic [7:0]        ob_n;
	logic              mem_n, isd_n, fe_n, done_n;

	logic [ABS_W-1:0]  page_abs;
	logic [DW-1:0]     d, len, col;
	logic [IDX_W-1:0]  idx;
	logic              in_pad, page_end;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	logic              addr_ok;

	logic [7:0]        out_byte_q;
	logic              is_data_q, frame_end_q, refresh_done_q;

	assign page_abs = (half_q ? ABS_W'(PAGES_PER_PASS) : ABS_W'(0)) + ABS_W'(page_q);
	assign d        = DW'(pos_q) - DW'(3);
	assign len      = DW'(COLUMNS) + (pad_columns ? DW'(2 * PAD_BYTES) : DW'(0));
	assign col      = pad_columns ? (d - DW'(PAD_BYTES)) : d;
	assign in_pad   = pad_columns && ((d < DW'(PAD_BYTES)) || (d >= DW'(COLUMNS + PAD_BYTES)));
	assign idx      = IDX_W'(page_abs) * IDX_W'(COLUMNS) + IDX_W'(col);

	// Next byte of the sequence and how the page, pass and phase counters move.
	always_comb begin
		ob_n      = '0;
		mem_n     = 1'b0;
		isd_n     = 1'b0;
		fe_n      = 1'b0;
		done_n    = 1'b0;
		page_end  = 1'b0;
		pos_nx    = pos_q + POS_W'(1);
		page_nx   = page_q;
		half_nx   = half_q;
		passes_nx = passes_q;
		phase_nx  = phase_q;
		if (phase_q == PH_FINAL) begin
			ob_n     = oled_panel ? CMD_OLED_ON : CMD_DISPLAY_ON;
			fe_n     = 1'b1;
			done_n   = 1'b1;
			pos_nx   = pos_q;
			phase_nx = PH_IDLE;
		end else begin
			priority if (pos_q == POS_W'(0)) begin
				ob_n = CMD_COL_LOW;
				fe_n = 1'b1;
			end else if (pos_q == POS_W'(1)) begin
				ob_n = CMD_COL_HIGH;
				fe_n = 1'b1;
			end else if (pos_q == POS_W'(2)) begin
				ob_n = CMD_PAGE_BASE | {4'h0, 4'(page_abs)};
				fe_n = 1'b1;
			end else begin
				isd_n = 1'b1;
				mem_n = !in_pad && (32'(col) < 32'(COLUMNS))
					&& (32'(idx) < 32'(BUFFER_BYTES));
				if (d + DW'(1) >= len) begin
					fe_n     = 1'b1;
					page_end = 1'b1;
				end
			end
			if (page_end) begin
				pos_nx = '0;
				if (page_q == PG_W'(PAGES_PER_PASS - 1)) begin
					page_nx = '0;
					half_nx = !half_q;
					if (phase_q == PH_FAST) begin
						done_n   = 1'b1;
						phase_nx = PH_IDLE;
					end else if (passes_q != 3'd0) begin
						passes_nx = passes_q - 3'd1;
					end else begin
						phase_nx = PH_FINAL;
					end
				end else begin
					page_nx = page_q + PG_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			half_q   <= 1'b0;
			page_q   <= '0;
			pos_q    <= '0;
			passes_q <= '0;
			clr_q    <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.start_fast || cmd.start_full) begin
				page_q <= '0;
				pos_q  <= '0;
				if (cmd.start_fast) begin
					passes_q <= '0;
					phase_q  <= PH_FAST;
				end else begin
					passes_q <= (full_passes == 3'd0) ? 3'd0 : full_passes - 3'd1;
					phase_q  <= PH_FULL;
				end
			end else if (cmd.pull) begin
				phase_q  <= phase_nx;
				half_q   <= half_nx;
				page_q   <= page_nx;
				pos_q    <= pos_nx;
				passes_q <= passes_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pull) begin
			ob_s1   <= ob_n;
			mem_s1  <= mem_n;
			isd_s1  <= isd_n;
			fe_s1   <= fe_n;
			done_s1 <= done_n;
		end
		if (cmd.load_out) begin
			out_byte_q     <= mem_s1 ? ram_rdata : ob_s1;
			is_data_q      <= isd_s1;
			frame_end_q    <= fe_s1;
			refresh_done_q <= done_s1;
		end
	end

	assign addr_ok   = 32'(address) < 32'(BUFFER_BYTES);
	assign ram_we    = cmd.clear_step || (cmd.write && addr_ok);
	assign ram_waddr = cmd.clear_step ? clr_q : AW'(address);
	assign ram_wdata = cmd.clear_step ? 8'h00 : data;

	lcdr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.pull),
		.raddr(AW'(idx)),
		.rdata(ram_rdata)
	);

	assign sts.phase_idle = (phase_q == PH_IDLE);
	assign sts.clear_last = (clr_q == AW'(BUFFER_BYTES - 1));

	assign out_byte     = out_byte_q;
	assign is_data      = is_data_q;
	assign frame_end    = frame_end_q;
	assign refresh_done = refresh_done_q;

	a_write_not_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.write && cmd.clear_step))
		else $error("buffer write collides with the clearing pass");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FAST || phase_q == PH_FULL) |-> (32'(pos_q) <= 32'(COLUMNS + 6)))
		else $error("byte position ran past the page frame");

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pull && done_n) |-> fe_n && (phase_nx == PH_IDLE))
		else $error("last refresh byte does not release chip select");

endmodule
